// ===== design/number_or_delimiter_tokenizer_macros.svh =====
// Assertion macros for the number_or_delimiter_tokenizer block.
// Bodies expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef NUMBER_OR_DELIMITER_TOKENIZER_MACROS_SVH
`define NUMBER_OR_DELIMITER_TOKENIZER_MACROS_SVH

// Same-cycle implication.
`define NDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ndt_pkg.sv =====
// Shared types and constants for the number_or_delimiter_tokenizer block.
// No dependencies; used by ndt_step and the top level.
package ndt_pkg;

  localparam int MAX_DELIMITER = 8;
  localparam int MAX_INPUT     = 4096;

  localparam int TAKEN_W    = $clog2(MAX_INPUT + 1);
  localparam int FILL_W     = ($clog2(MAX_DELIMITER) > 0) ? $clog2(MAX_DELIMITER) : 1;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NONUM = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 2'd2;

  typedef enum logic [1:0] {
    PH_OUT   = 2'd0,
    PH_MINUS = 2'd1,
    PH_INT   = 2'd2,
    PH_FRAC  = 2'd3
  } phase_t;

  typedef logic [MAX_DELIMITER-1:0][7:0] window_t;

  typedef struct packed {
    phase_t              phase;
    logic [FILL_W-1:0]   fill;
    logic                seen;
    logic [TAKEN_W-1:0]  taken;
  } ctl_t;

  typedef struct packed {
    logic       emit;
    logic       done;
    logic [7:0] data;
    logic       kind;
    logic       last;
    logic [1:0] status;
  } res_t;

endpackage

// ===== design/ndt_step.sv =====
// One step of the tokenizer: from held item, state and config, at most one result.
// Depends on ndt_pkg.
module ndt_step (
  input  logic [7:0]                    item_byte,
  input  logic                          item_end,
  input  logic                          split_mode,
  input  logic [ndt_pkg::LEN_W-1:0]     sep_len,
  input  ndt_pkg::window_t              delim_bytes,
  input  ndt_pkg::ctl_t                 ctl_cur,
  input  ndt_pkg::window_t              win_cur,
  output ndt_pkg::ctl_t                 ctl_nxt,
  output ndt_pkg::window_t              win_nxt,
  output ndt_pkg::res_t                 res
);

  function automatic ndt_pkg::window_t shift_win(ndt_pkg::window_t w);
    ndt_pkg::window_t s;
    s = w;
    for (int i = 0; i < ndt_pkg::MAX_DELIMITER - 1; i++) begin
      s[i] = w[i+1];
    end
    return s;
  endfunction

  logic [ndt_pkg::LEN_W-1:0] len;
  logic [ndt_pkg::LEN_W-1:0] fill4;
  logic                      is_dig;
  logic                      is_dot;
  logic                      is_minus;
  logic                      end_final;
  logic                      hit;
  ndt_pkg::window_t          w_ins;
  ndt_pkg::phase_t           ph_nxt;

  assign len = (sep_len > ndt_pkg::LEN_W'(ndt_pkg::MAX_DELIMITER)) ?
               ndt_pkg::LEN_W'(ndt_pkg::MAX_DELIMITER) : sep_len;
  assign fill4    = ndt_pkg::LEN_W'(ctl_cur.fill);
  assign is_dig   = (item_byte >= ndt_pkg::CH_ZERO) && (item_byte <= ndt_pkg::CH_NINE);
  assign is_dot   = (item_byte == ndt_pkg::CH_DOT);
  assign is_minus = (item_byte == ndt_pkg::CH_MINUS);
  assign end_final = !split_mode || (len == '0) || (ctl_cur.fill == '0);

  always_comb begin
    w_ins = win_cur;
    w_ins[ctl_cur.fill] = item_byte;
    hit = 1'b1;
    for (int i = 0; i < ndt_pkg::MAX_DELIMITER; i++) begin
      if ((ndt_pkg::LEN_W'(i) < len) && (w_ins[i] != delim_bytes[i])) begin
        hit = 1'b0;
      end
    end
  end

  // Number phase next state
  always_comb begin
    ph_nxt = ctl_cur.phase;
    if (item_end) begin
      if (end_final) begin
        ph_nxt = ndt_pkg::PH_OUT;
      end
    end else if (!split_mode) begin
      unique case (ctl_cur.phase)
        ndt_pkg::PH_OUT: begin
          if (is_dig)        ph_nxt = ndt_pkg::PH_INT;
          else if (is_dot)   ph_nxt = ndt_pkg::PH_FRAC;
          else if (is_minus) ph_nxt = ndt_pkg::PH_MINUS;
          else               ph_nxt = ndt_pkg::PH_OUT;
        end
        ndt_pkg::PH_MINUS: begin
          if (is_minus) ph_nxt = ndt_pkg::PH_MINUS;
          else          ph_nxt = ndt_pkg::PH_OUT;
        end
        ndt_pkg::PH_INT: begin
          if (is_dig)        ph_nxt = ndt_pkg::PH_INT;
          else if (is_dot)   ph_nxt = ndt_pkg::PH_FRAC;
          else if (is_minus) ph_nxt = ndt_pkg::PH_MINUS;
          else               ph_nxt = ndt_pkg::PH_OUT;
        end
        ndt_pkg::PH_FRAC: begin
          if (is_dig)        ph_nxt = ndt_pkg::PH_FRAC;
          else if (is_minus) ph_nxt = ndt_pkg::PH_MINUS;
          else               ph_nxt = ndt_pkg::PH_OUT;
        end
        default: ph_nxt = ndt_pkg::PH_OUT;
      endcase
    end
  end

  // Result and remaining state
  always_comb begin
    res        = '0;
    res.kind   = ndt_pkg::KIND_BYTE;
    res.status = ndt_pkg::ST_OK;
    res.done   = 1'b1;
    win_nxt    = win_cur;
    ctl_nxt    = ctl_cur;
    ctl_nxt.phase = ph_nxt;

    if (item_end) begin
      if (end_final) begin
        res.emit = 1'b1;
        res.kind = ndt_pkg::KIND_END;
        res.last = 1'b1;
        if (ctl_cur.taken >= ndt_pkg::TAKEN_W'(ndt_pkg::MAX_INPUT)) begin
          res.status = ndt_pkg::ST_LONG;
        end else if (!split_mode && !ctl_cur.seen) begin
          res.status = ndt_pkg::ST_NONUM;
        end else if (split_mode && (len == '0)) begin
          res.status = ndt_pkg::ST_EMPTY;
        end
        ctl_nxt.fill  = '0;
        ctl_nxt.seen  = 1'b0;
        ctl_nxt.taken = '0;
      end else begin
        // flush held window bytes one per step
        res.emit     = 1'b1;
        res.data     = win_cur[0];
        res.done     = 1'b0;
        win_nxt      = shift_win(win_cur);
        ctl_nxt.fill = ctl_cur.fill - 1'b1;
      end
    end else begin
      if (!split_mode) begin
        unique case (ctl_cur.phase)
          ndt_pkg::PH_OUT: begin
            res.emit = is_dig || is_dot;
            res.data = item_byte;
            if (is_dig || is_dot) ctl_nxt.seen = 1'b1;
          end
          ndt_pkg::PH_MINUS: begin
            res.emit = is_dig || is_dot;
            res.data = ndt_pkg::CH_MINUS;
            res.done = !(is_dig || is_dot);
          end
          ndt_pkg::PH_INT: begin
            res.emit = 1'b1;
            if (is_dig || is_dot) res.data = item_byte;
            else                  res.kind = ndt_pkg::KIND_END;
          end
          ndt_pkg::PH_FRAC: begin
            res.emit = 1'b1;
            if (is_dig) begin
              res.data = item_byte;
            end else begin
              res.kind = ndt_pkg::KIND_END;
              res.done = !is_dot;
            end
          end
          default: res.emit = 1'b0;
        endcase
      end else if (len != '0) begin
        if (fill4 >= len) begin
          // delimiter shrank: drain oldest bytes first
          res.emit     = 1'b1;
          res.data     = win_cur[0];
          res.done     = 1'b0;
          win_nxt      = shift_win(win_cur);
          ctl_nxt.fill = ctl_cur.fill - 1'b1;
        end else if ((fill4 + 1'b1) < len) begin
          win_nxt      = w_ins;
          ctl_nxt.fill = ndt_pkg::FILL_W'(fill4 + 1'b1);
        end else if (hit) begin
          res.emit     = 1'b1;
          res.kind     = ndt_pkg::KIND_END;
          win_nxt      = w_ins;
          ctl_nxt.fill = '0;
        end else begin
          res.emit = 1'b1;
          res.data = w_ins[0];
          win_nxt  = shift_win(w_ins);
        end
      end
      if (res.done && (ctl_cur.taken < ndt_pkg::TAKEN_W'(ndt_pkg::MAX_INPUT))) begin
        ctl_nxt.taken = ctl_cur.taken + 1'b1;
      end
    end
  end

endmodule

// ===== design/number_or_delimiter_tokenizer.sv =====
// Top level of the number_or_delimiter_tokenizer block: channels, registers, config.
// Depends on ndt_pkg, ndt_step and number_or_delimiter_tokenizer_macros.svh.
//
// Usage:
//  Input stream in_*: one character per item in in_tdata; in_tlast marks the end
//  item, whose data is ignored. Result stream out_*: out_tdata carries the token
//  character and the status, out_tuser is 0 for a token byte and 1 for a token end,
//  out_tlast flags the final result of an end item (status valid only there).
//  Config channel cfg_*: index 0 split mode, 1 delimiter length, 2 delimiter bytes;
//  always ready, write only while the stream is idle.
//  An accepted item is held in the input register; its result is registered onto out_*.
//  Throughput: one item per cycle while each item yields at most one result and out_tready is high.
//  An item yielding several results holds the step unit until all are out, one result each
//  (numeric mode: up to 2, delimiter mode: up to 8 when the window flushes).
//  An item with no result retires without waiting for the receiver.
//  Reset: config returns to numeric mode, delimiter ",", state cleared; no item held.
//  Receiver stall: the output register holds its result; the input register still
//  takes items, but one that yields a result waits there with in_tready low until space frees.
`include "number_or_delimiter_tokenizer_macros.svh"
module number_or_delimiter_tokenizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ndt_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ndt_pkg::OUT_DATA_W-1:0]    out_tdata,  // [7:0] out_byte, [9:8] status
  output logic                              out_tuser,  // [0] item_kind
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ndt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ndt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                      split_mode_r;
  logic [ndt_pkg::LEN_W-1:0] sep_len_r;
  ndt_pkg::window_t          delim_bytes_r;

  logic                      item_valid_r;
  logic [7:0]                item_byte_r;
  logic                      item_end_r;

  ndt_pkg::ctl_t             ctl_r;
  ndt_pkg::ctl_t             ctl_nxt;
  ndt_pkg::window_t          win_r;
  ndt_pkg::window_t          win_nxt;
  ndt_pkg::res_t             res;

  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_kind_r;
  logic                      out_last_r;
  logic [1:0]                out_status_r;

  logic                      out_free;
  logic                      step_fire;
  logic                      in_fire;

  logic                      out_is_end;
  logic                      status_ok;
  logic                      end_step;
  logic                      ctl_clear;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_mode_r  <= 1'b0;
      sep_len_r     <= ndt_pkg::LEN_W'(1);
      delim_bytes_r <= ndt_pkg::window_t'(ndt_pkg::CH_COMMA);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ndt_pkg::REG_SPLIT_MODE:  split_mode_r  <= cfg_data[0];
        ndt_pkg::REG_DELIM_LEN:   sep_len_r     <= cfg_data[ndt_pkg::LEN_W-1:0];
        ndt_pkg::REG_DELIM_BYTES: delim_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ndt_step u_step (
    .item_byte   (item_byte_r),
    .item_end    (item_end_r),
    .split_mode  (split_mode_r),
    .sep_len     (sep_len_r),
    .delim_bytes (delim_bytes_r),
    .ctl_cur     (ctl_r),
    .win_cur     (win_r),
    .ctl_nxt     (ctl_nxt),
    .win_nxt     (win_nxt),
    .res         (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign step_fire = item_valid_r && (out_free || !res.emit);
  assign in_tready = !item_valid_r || (step_fire && res.done);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_fire) begin
      item_valid_r <= 1'b1;
    end else if (step_fire && res.done) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_byte_r <= in_tdata;
      item_end_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (step_fire) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_fire && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res.emit) begin
      out_byte_r   <= res.data;
      out_kind_r   <= res.kind;
      out_last_r   <= res.last;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ndt_pkg::OUT_DATA_W - 10){1'b0}}, out_status_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  assign out_is_end = (out_kind_r == ndt_pkg::KIND_END);
  assign status_ok  = (out_status_r == ndt_pkg::ST_OK);
  assign end_step   = step_fire && res.done && item_end_r;
  assign ctl_clear  = (ctl_r.phase == ndt_pkg::PH_OUT) && (ctl_r.fill == '0) &&
                      !ctl_r.seen && (ctl_r.taken == '0);

  `NDT_ASSERT_NOW(a_last_is_end, out_valid_r && out_last_r, out_is_end, "last not a token end")
  `NDT_ASSERT_NOW(a_status_on_last, out_valid_r && !out_last_r, status_ok, "status on non-final")
  `NDT_ASSERT_NOW(a_end_has_no_byte, out_valid_r && out_is_end, out_byte_r == 8'h00, "end has byte")
  `NDT_ASSERT_NEXT(a_end_clears, end_step, ctl_clear, "end item left state behind")
  `NDT_ASSERT_NEXT(a_stall_holds, item_valid_r && !step_fire, $stable(ctl_r), "state moved in stall")

endmodule
